// ===== hdl/sht_pkg.sv =====
// Shared types and constants for the shape hit tester.
package sht_pkg;

    localparam int SHT_COORD_BITS = 16;
    localparam int SHT_STAGES     = 6;
    localparam int SHT_OUT_BITS   = 8;
    localparam int SHT_SEG_LANES  = 4;
    localparam int SHT_TRI_LANES  = 2;

    typedef enum logic [2:0] {
        REQ_PT_RECT  = 3'd0,
        REQ_PT_TRI   = 3'd1,
        REQ_SEG_SEG  = 3'd2,
        REQ_SEG_RECT = 3'd3,
        REQ_SEG_ELL  = 3'd4,
        REQ_SEG_TRI  = 3'd5
    } t_req;

    // sign of a cross product
    typedef struct packed {
        logic neg;
        logic zero;
    } t_sgn;

    // load enables of the two cross-product stages
    typedef struct packed {
        logic mul;
        logic sub;
    } t_cross_en;

endpackage

// ===== hdl/sht_cross.sv =====
// Two-stage sign of the 2D cross product ax*by - ay*bx.
module sht_cross #(
    parameter int IN_BITS = sht_pkg::SHT_COORD_BITS + 2
) (
    input  logic                      i_clk,
    input  sht_pkg::t_cross_en        i_en,
    input  logic signed [IN_BITS-1:0] i_ax,
    input  logic signed [IN_BITS-1:0] i_ay,
    input  logic signed [IN_BITS-1:0] i_bx,
    input  logic signed [IN_BITS-1:0] i_by,
    output sht_pkg::t_sgn             o_sgn
);
    import sht_pkg::*;

    localparam int PW = 2 * IN_BITS;

    logic signed [PW-1:0] r_p1, r_p2, n_p1, n_p2;
    logic signed [PW:0]   n_diff;
    t_sgn                 r_sgn, n_sgn;

    always_comb begin
        n_p1       = PW'(i_ax) * PW'(i_by);
        n_p2       = PW'(i_ay) * PW'(i_bx);
        n_diff     = (PW+1)'(r_p1) - (PW+1)'(r_p2);
        n_sgn.neg  = n_diff[PW];
        n_sgn.zero = (n_diff == '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
        end
        if (i_en.sub) begin
            r_sgn <= n_sgn;
        end
    end

    assign o_sgn = r_sgn;

endmodule

// ===== hdl/shape_hit_test.sv =====
// Top level of the pipelined 2D shape hit tester.
//
// Usage: present one request word per cycle on the slave stream. tuser holds
// the test kind (point-rect, point-tri, seg-seg, seg-rect, seg-ellipse,
// seg-tri); tdata holds ten signed coordinates of COORD_BITS each. Every
// accepted word yields exactly one result word on the master stream, whose
// bit 0 is the hit flag. Unknown kinds answer a miss.
// Stages from acceptance to the result on the master side: difference,
// product, square/cross, sum, compare and select.
// Throughput: one word per cycle while the master side is ready; each of
// the six stages holds its own valid bit.
// Reset (synchronous, active low) clears all valid bits; the data registers
// are not reset. When the receiver stalls, the output word holds and each
// stage keeps loading until it meets a full stage in front of it, so empty
// slots close up and input is still taken until the pipe is full. Nothing is
// dropped or repeated. Boundary, touching and collinear contacts miss.
module shape_hit_test #(
    parameter int COORD_BITS = sht_pkg::SHT_COORD_BITS,
    localparam int TDATA_BITS = ((10 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // start_x, start_y, end_x, end_y, shape_a_x, shape_a_y,
    // shape_b_x, shape_b_y, shape_c_x, shape_c_y, zero padding
    input  logic [TDATA_BITS-1:0]            i_s_tdata,
    // req_type
    input  logic [2:0]                       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // hit, zero padding
    output logic [sht_pkg::SHT_OUT_BITS-1:0] o_m_tdata
);
    import sht_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int W1  = C + 1;        // single coordinate difference
    localparam int W2  = C + 2;        // difference against a rectangle corner
    localparam int P1  = 2 * C + 1;    // coordinate difference times radius
    localparam int PK  = 2 * C + 2;    // product of two differences
    localparam int KW  = 2 * C + 3;    // ellipse line cross term
    localparam int Q   = 2 * P1;       // squares of scaled terms
    localparam int SW  = Q + 1;        // sum of two squares
    localparam int KQ  = 2 * KW;       // square of the cross term
    localparam int NL  = SHT_SEG_LANES;
    localparam int NT  = SHT_TRI_LANES;

    // ---------------- stage handshake ----------------
    logic [SHT_STAGES:1]   r_vld;
    logic [SHT_STAGES+1:1] adv;

    always_comb begin
        adv[SHT_STAGES+1] = i_m_tready;
        for (int k = SHT_STAGES; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= SHT_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = adv[1];
    assign o_m_tvalid = r_vld[SHT_STAGES];

    // ---------------- unpack ----------------
    logic signed [C-1:0] sx, sy, ex, ey, ax, ay, bx, by, cx, cy;

    assign sx = $signed(i_s_tdata[0*C +: C]);
    assign sy = $signed(i_s_tdata[1*C +: C]);
    assign ex = $signed(i_s_tdata[2*C +: C]);
    assign ey = $signed(i_s_tdata[3*C +: C]);
    assign ax = $signed(i_s_tdata[4*C +: C]);
    assign ay = $signed(i_s_tdata[5*C +: C]);
    assign bx = $signed(i_s_tdata[6*C +: C]);
    assign by = $signed(i_s_tdata[7*C +: C]);
    assign cx = $signed(i_s_tdata[8*C +: C]);
    assign cy = $signed(i_s_tdata[9*C +: C]);

    // ---------------- stage 1: edge endpoints, centre offsets ----------------
    logic [2:0]           r1_type;
    logic signed [C-1:0]  r1_sx, r1_sy, r1_ex, r1_ey;
    logic signed [C-1:0]  r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [W1-1:0] r1_q1x [NL], r1_q1y [NL], r1_q2x [NL], r1_q2y [NL];
    logic signed [W1-1:0] n_q1x [NL], n_q1y [NL], n_q2x [NL], n_q2y [NL];
    logic signed [W1-1:0] r1_c1x, r1_c1y, r1_c2x, r1_c2y, r1_dx, r1_dy;
    logic signed [W1-1:0] rl, rr, rt, rb, wax, way, wbx, wby, wcx, wcy;

    always_comb begin
        wax = W1'(ax);
        way = W1'(ay);
        wbx = W1'(bx);
        wby = W1'(by);
        wcx = W1'(cx);
        wcy = W1'(cy);
        // rectangle outline from centre and half-extents
        rl  = wax - wbx;
        rr  = wax + wbx;
        rt  = way + wby;
        rb  = way - wby;
        if (i_s_tuser == REQ_SEG_RECT) begin
            n_q1x[0] = rl; n_q1y[0] = rt; n_q2x[0] = rl; n_q2y[0] = rb;
            n_q1x[1] = rl; n_q1y[1] = rb; n_q2x[1] = rr; n_q2y[1] = rb;
            n_q1x[2] = rr; n_q1y[2] = rb; n_q2x[2] = rr; n_q2y[2] = rt;
        end else begin
            n_q1x[0] = wax; n_q1y[0] = way; n_q2x[0] = wbx; n_q2y[0] = wby;
            n_q1x[1] = wbx; n_q1y[1] = wby; n_q2x[1] = wcx; n_q2y[1] = wcy;
            n_q1x[2] = wcx; n_q1y[2] = wcy; n_q2x[2] = wax; n_q2y[2] = way;
        end
        n_q1x[3] = rr; n_q1y[3] = rt; n_q2x[3] = rl; n_q2y[3] = rt;
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_type <= i_s_tuser;
            r1_sx   <= sx;
            r1_sy   <= sy;
            r1_ex   <= ex;
            r1_ey   <= ey;
            r1_ax   <= ax;
            r1_ay   <= ay;
            r1_bx   <= bx;
            r1_by   <= by;
            r1_cx   <= cx;
            r1_cy   <= cy;
            for (int i = 0; i < NL; i++) begin
                r1_q1x[i] <= n_q1x[i];
                r1_q1y[i] <= n_q1y[i];
                r1_q2x[i] <= n_q2x[i];
                r1_q2y[i] <= n_q2y[i];
            end
            r1_c1x  <= wax - W1'(sx);
            r1_c1y  <= way - W1'(sy);
            r1_c2x  <= wax - W1'(ex);
            r1_c2y  <= way - W1'(ey);
            r1_dx   <= W1'(ex) - W1'(sx);
            r1_dy   <= W1'(ey) - W1'(sy);
        end
    end

    // ---------------- stage 2: edge vectors, first ellipse products ----------------
    logic [2:0]           r2_type;
    logic signed [W1-1:0] r2_ux, r2_uy;
    logic signed [W2-1:0] r2_vx [NL], r2_vy [NL], r2_w1x [NL], r2_w1y [NL];
    logic signed [W2-1:0] r2_w2x [NL], r2_w2y [NL], r2_z1x [NL], r2_z1y [NL];
    logic signed [W2-1:0] r2_z2x [NL], r2_z2y [NL];
    logic signed [W1-1:0] r2_e1x, r2_e1y, r2_e2x, r2_e2y, r2_e3x, r2_e3y;
    logic signed [W1-1:0] r2_d1x [NT], r2_d1y [NT], r2_d2x [NT], r2_d2y [NT];
    logic signed [W1-1:0] r2_d3x [NT], r2_d3y [NT];
    logic signed [W1-1:0] r2_abs_c1x, r2_abs_c1y, r2_abs_c2x, r2_abs_c2y;
    logic signed [C-1:0]  r2_hw, r2_hh;
    logic signed [P1-1:0] r2_a1, r2_b1, r2_a2, r2_b2, r2_ad, r2_bd, r2_rr;
    logic signed [PK-1:0] r2_k1, r2_k2;
    logic                 r2_rz;
    logic signed [W1-1:0] tpx [NT], tpy [NT];

    always_comb begin
        tpx[0] = W1'(r1_sx);
        tpy[0] = W1'(r1_sy);
        tpx[1] = W1'(r1_ex);
        tpy[1] = W1'(r1_ey);
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_type <= r1_type;
            r2_ux   <= r1_dx;
            r2_uy   <= r1_dy;
            for (int i = 0; i < NL; i++) begin
                r2_vx[i]  <= W2'(r1_q2x[i]) - W2'(r1_q1x[i]);
                r2_vy[i]  <= W2'(r1_q2y[i]) - W2'(r1_q1y[i]);
                r2_w1x[i] <= W2'(r1_q1x[i]) - W2'(r1_sx);
                r2_w1y[i] <= W2'(r1_q1y[i]) - W2'(r1_sy);
                r2_w2x[i] <= W2'(r1_q2x[i]) - W2'(r1_sx);
                r2_w2y[i] <= W2'(r1_q2y[i]) - W2'(r1_sy);
                r2_z1x[i] <= W2'(r1_sx) - W2'(r1_q1x[i]);
                r2_z1y[i] <= W2'(r1_sy) - W2'(r1_q1y[i]);
                r2_z2x[i] <= W2'(r1_ex) - W2'(r1_q1x[i]);
                r2_z2y[i] <= W2'(r1_ey) - W2'(r1_q1y[i]);
            end
            r2_e1x <= W1'(r1_bx) - W1'(r1_ax);
            r2_e1y <= W1'(r1_by) - W1'(r1_ay);
            r2_e2x <= W1'(r1_cx) - W1'(r1_bx);
            r2_e2y <= W1'(r1_cy) - W1'(r1_by);
            r2_e3x <= W1'(r1_ax) - W1'(r1_cx);
            r2_e3y <= W1'(r1_ay) - W1'(r1_cy);
            for (int j = 0; j < NT; j++) begin
                r2_d1x[j] <= tpx[j] - W1'(r1_ax);
                r2_d1y[j] <= tpy[j] - W1'(r1_ay);
                r2_d2x[j] <= tpx[j] - W1'(r1_bx);
                r2_d2y[j] <= tpy[j] - W1'(r1_by);
                r2_d3x[j] <= tpx[j] - W1'(r1_cx);
                r2_d3y[j] <= tpy[j] - W1'(r1_cy);
            end
            r2_abs_c1x <= r1_c1x[W1-1] ? -r1_c1x : r1_c1x;
            r2_abs_c1y <= r1_c1y[W1-1] ? -r1_c1y : r1_c1y;
            r2_abs_c2x <= r1_c2x[W1-1] ? -r1_c2x : r1_c2x;
            r2_abs_c2y <= r1_c2y[W1-1] ? -r1_c2y : r1_c2y;
            r2_hw   <= r1_bx;
            r2_hh   <= r1_by;
            // ellipse terms scaled by the radii
            r2_a1   <= P1'(r1_c1x) * P1'(r1_by);
            r2_b1   <= P1'(r1_c1y) * P1'(r1_bx);
            r2_a2   <= P1'(r1_c2x) * P1'(r1_by);
            r2_b2   <= P1'(r1_c2y) * P1'(r1_bx);
            r2_ad   <= P1'(r1_dx) * P1'(r1_by);
            r2_bd   <= P1'(r1_dy) * P1'(r1_bx);
            r2_rr   <= P1'(r1_bx) * P1'(r1_by);
            r2_k1   <= PK'(r1_dx) * PK'(r1_c1y);
            r2_k2   <= PK'(r1_dy) * PK'(r1_c1x);
            r2_rz   <= (r1_bx == '0) || (r1_by == '0);
        end
    end

    // ---------------- stages 3 and 4: cross-product signs ----------------
    t_cross_en cen;
    t_sgn      w_sa [NL], w_sb [NL], w_sc [NL], w_sd [NL];
    t_sgn      w_s1 [NT], w_s2 [NT], w_s3 [NT];

    assign cen = '{mul: adv[3], sub: adv[4]};

    for (genvar g = 0; g < NL; g++) begin : g_seg
        sht_cross #(.IN_BITS(W2)) u_a (
            .i_clk(i_clk), .i_en(cen),
            .i_ax(W2'(r2_ux)), .i_ay(W2'(r2_uy)),
            .i_bx(r2_w1x[g]), .i_by(r2_w1y[g]), .o_sgn(w_sa[g])
        );
        sht_cross #(.IN_BITS(W2)) u_b (
            .i_clk(i_clk), .i_en(cen),
            .i_ax(W2'(r2_ux)), .i_ay(W2'(r2_uy)),
            .i_bx(r2_w2x[g]), .i_by(r2_w2y[g]), .o_sgn(w_sb[g])
        );
        sht_cross #(.IN_BITS(W2)) u_c (
            .i_clk(i_clk), .i_en(cen),
            .i_ax(r2_vx[g]), .i_ay(r2_vy[g]),
            .i_bx(r2_z1x[g]), .i_by(r2_z1y[g]), .o_sgn(w_sc[g])
        );
        sht_cross #(.IN_BITS(W2)) u_d (
            .i_clk(i_clk), .i_en(cen),
            .i_ax(r2_vx[g]), .i_ay(r2_vy[g]),
            .i_bx(r2_z2x[g]), .i_by(r2_z2y[g]), .o_sgn(w_sd[g])
        );
    end

    for (genvar g = 0; g < NT; g++) begin : g_tri
        sht_cross #(.IN_BITS(W2)) u_1 (
            .i_clk(i_clk), .i_en(cen),
            .i_ax(W2'(r2_d1x[g])), .i_ay(W2'(r2_d1y[g])),
            .i_bx(W2'(r2_e1x)), .i_by(W2'(r2_e1y)), .o_sgn(w_s1[g])
        );
        sht_cross #(.IN_BITS(W2)) u_2 (
            .i_clk(i_clk), .i_en(cen),
            .i_ax(W2'(r2_d2x[g])), .i_ay(W2'(r2_d2y[g])),
            .i_bx(W2'(r2_e2x)), .i_by(W2'(r2_e2y)), .o_sgn(w_s2[g])
        );
        sht_cross #(.IN_BITS(W2)) u_3 (
            .i_clk(i_clk), .i_en(cen),
            .i_ax(W2'(r2_d3x[g])), .i_ay(W2'(r2_d3y[g])),
            .i_bx(W2'(r2_e3x)), .i_by(W2'(r2_e3y)), .o_sgn(w_s3[g])
        );
    end

    // ---------------- stage 3: rectangle compare, ellipse squares ----------------
    logic [2:0]           r3_type;
    logic                 r3_in_s, r3_in_e, r3_rz;
    logic signed [Q-1:0]  r3_a1sq, r3_b1sq, r3_a2sq, r3_b2sq, r3_adsq, r3_bdsq;
    logic signed [Q-1:0]  r3_rrsq, r3_m1, r3_m2, r3_m3, r3_m4;
    logic signed [KW-1:0] r3_k;

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_type <= r2_type;
            r3_in_s <= (r2_abs_c1x < W1'(r2_hw)) && (r2_abs_c1y < W1'(r2_hh));
            r3_in_e <= (r2_abs_c2x < W1'(r2_hw)) && (r2_abs_c2y < W1'(r2_hh));
            r3_rz   <= r2_rz;
            r3_a1sq <= Q'(r2_a1) * Q'(r2_a1);
            r3_b1sq <= Q'(r2_b1) * Q'(r2_b1);
            r3_a2sq <= Q'(r2_a2) * Q'(r2_a2);
            r3_b2sq <= Q'(r2_b2) * Q'(r2_b2);
            r3_adsq <= Q'(r2_ad) * Q'(r2_ad);
            r3_bdsq <= Q'(r2_bd) * Q'(r2_bd);
            r3_rrsq <= Q'(r2_rr) * Q'(r2_rr);
            r3_m1   <= Q'(r2_a1) * Q'(r2_ad);
            r3_m2   <= Q'(r2_b1) * Q'(r2_bd);
            r3_m3   <= Q'(r2_a2) * Q'(r2_ad);
            r3_m4   <= Q'(r2_b2) * Q'(r2_bd);
            r3_k    <= KW'(r2_k1) - KW'(r2_k2);
        end
    end

    // ---------------- stage 4: ellipse sums ----------------
    logic [2:0]           r4_type;
    logic                 r4_in_s, r4_in_e, r4_rz;
    logic signed [SW-1:0] r4_sum1, r4_sum2, r4_len, r4_d1, r4_e2;
    logic signed [Q-1:0]  r4_rrsq;
    logic signed [KQ-1:0] r4_ksq;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_type <= r3_type;
            r4_in_s <= r3_in_s;
            r4_in_e <= r3_in_e;
            r4_rz   <= r3_rz;
            r4_sum1 <= SW'(r3_a1sq) + SW'(r3_b1sq);
            r4_sum2 <= SW'(r3_a2sq) + SW'(r3_b2sq);
            r4_len  <= SW'(r3_adsq) + SW'(r3_bdsq);
            r4_d1   <= SW'(r3_m1) + SW'(r3_m2);
            r4_e2   <= SW'(r3_m3) + SW'(r3_m4);
            r4_rrsq <= r3_rrsq;
            r4_ksq  <= KQ'(r3_k) * KQ'(r3_k);
        end
    end

    // ---------------- stage 5: per-test verdicts ----------------
    logic [2:0]    r5_type;
    logic          r5_in_s, r5_in_e, r5_ell;
    logic [NL-1:0] r5_seg, n_seg;
    logic [NT-1:0] r5_tri, n_tri;
    logic          n_ell, ell_in1, ell_in2, ell_near, ell_span;

    always_comb begin
        for (int i = 0; i < NL; i++) begin
            // strict crossing: both pairs straddle with nonzero signs
            n_seg[i] = !w_sa[i].zero && !w_sb[i].zero && (w_sa[i].neg != w_sb[i].neg)
                    && !w_sc[i].zero && !w_sd[i].zero && (w_sc[i].neg != w_sd[i].neg);
        end
        for (int j = 0; j < NT; j++) begin
            n_tri[j] = !w_s1[j].zero && !w_s2[j].zero && !w_s3[j].zero
                    && (w_s1[j].neg == w_s2[j].neg) && (w_s1[j].neg == w_s3[j].neg);
        end
        ell_in1  = SW'(r4_sum1) < SW'(r4_rrsq);
        ell_in2  = SW'(r4_sum2) < SW'(r4_rrsq);
        ell_near = r4_ksq < KQ'(r4_len);
        // closest point lies within the segment span
        ell_span = (r4_d1 == '0) || (r4_e2 == '0) || (r4_d1[SW-1] != r4_e2[SW-1]);
        n_ell    = !r4_rz && (ell_in1 || ell_in2 || (ell_near && ell_span));
    end

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_type <= r4_type;
            r5_in_s <= r4_in_s;
            r5_in_e <= r4_in_e;
            r5_seg  <= n_seg;
            r5_tri  <= n_tri;
            r5_ell  <= n_ell;
        end
    end

    // ---------------- stage 6: select by kind, output word ----------------
    logic r6_hit, n_hit;

    always_comb begin
        unique case (r5_type)
            REQ_PT_RECT:  n_hit = r5_in_s;
            REQ_PT_TRI:   n_hit = r5_tri[0];
            REQ_SEG_SEG:  n_hit = r5_seg[0];
            REQ_SEG_RECT: n_hit = r5_in_s || r5_in_e || (|r5_seg);
            REQ_SEG_ELL:  n_hit = r5_ell;
            REQ_SEG_TRI:  n_hit = r5_seg[0] || r5_seg[1] || r5_seg[2] || (|r5_tri);
            default:      n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_hit <= n_hit;
        end
    end

    assign o_m_tdata = {(SHT_OUT_BITS-1)'(0), r6_hit};

endmodule
